>>> rtl/fkpc_pkg.sv
// Shared types and codes for the flow-keyed packet counter table.
`default_nettype none
package fkpc_pkg;

  localparam int KEY_W   = 48;
  localparam int COUNT_W = 32;

  typedef enum logic [1:0] {
    ST_COUNTED = 2'd0,
    ST_REMOVED = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic {
    REQ_COUNT = 1'b0,
    REQ_CLOSE = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic        req_type;
    logic [31:0] src_addr;
    logic [15:0] src_port;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] count_value;
  } rsp_t;

  // One table entry as stored in memory.
  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic clr;  // start of a scan
    logic vld;  // read data present this cycle
  } scan_ctl_t;

  typedef struct packed {
    logic hit;
    logic free;
  } scan_sts_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

>>> rtl/flow_keyed_packet_counter_table.sv
// Top level: sequencer, table memory and result register of the flow counter table.
//
//   channel | ports                | handshake
//   --------+----------------------+----------------------------------------
//   request | start, busy, in_req  | taken at an edge with start high, busy low
//   result  | out_valid, out_rsp   | one-cycle strobe, one result per request
//
// Each request scans every table entry through one memory read port, one
// entry a cycle, then updates the chosen entry, if any. A new request is taken
// only once busy has dropped, after the update. The result strobe rises in the
// cycle busy drops. After reset a clearing pass over every entry empties the
// table, with busy held high. The receiver cannot stall; results are never held.
`default_nettype none
module flow_keyed_packet_counter_table
  import fkpc_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire req_t in_req,
  output logic      out_valid,
  output rsp_t      out_rsp
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  req_t          req_r, req_nxt;
  logic          out_valid_r, out_valid_nxt;
  rsp_t          out_rsp_r, out_rsp_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic          ram_re;
  entry_t        ram_rdata;

  scan_ctl_t          scan_ctl;
  scan_sts_t          scan_sts;
  logic [AW-1:0]      hit_idx;
  logic [AW-1:0]      free_idx;
  logic [COUNT_W-1:0] hit_count;
  logic [KEY_W-1:0]   req_key;
  logic [COUNT_W-1:0] count_inc;

  assign req_key   = {req_r.src_addr, req_r.src_port};
  assign count_inc = (hit_count == COUNT_MAX) ? COUNT_MAX : hit_count + COUNT_W'(1);

  fkpc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  fkpc_scan #(
    .AW (AW)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (scan_ctl),
    .rd_idx    (rd_idx_r),
    .key       (req_key),
    .rd_entry  (ram_rdata),
    .sts       (scan_sts),
    .hit_idx   (hit_idx),
    .free_idx  (free_idx),
    .hit_count (hit_count)
  );

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    rd_idx_nxt    = idx_r;
    rd_vld_nxt    = 1'b0;
    req_nxt       = req_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    scan_ctl      = '0;
    scan_ctl.vld  = rd_vld_r;
    unique case (state_r)
      S_CLEAR: begin
        // wipe one entry a cycle
        ram_we = 1'b1;
        if (idx_r == LAST) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (start) begin
          req_nxt      = in_req;
          idx_nxt      = '0;
          scan_ctl.clr = 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        ram_re     = 1'b1;
        rd_vld_nxt = 1'b1;
        if (idx_r == LAST) begin
          idx_nxt   = '0;
          state_nxt = S_DRAIN;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_DRAIN: begin
        // last entry is compared this cycle
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        out_valid_nxt           = 1'b1;
        out_rsp_nxt.count_value = '0;
        state_nxt               = S_IDLE;
        if (req_r.req_type == REQ_CLOSE) begin
          if (scan_sts.hit) begin
            ram_we                 = 1'b1;
            ram_waddr              = hit_idx;
            out_rsp_nxt.status     = ST_REMOVED;
          end else begin
            out_rsp_nxt.status     = ST_UNKNOWN;
          end
        end else if (scan_sts.hit) begin
          ram_we                  = 1'b1;
          ram_waddr               = hit_idx;
          ram_wdata               = '{valid: 1'b1, key: req_key, count: count_inc};
          out_rsp_nxt.status      = ST_COUNTED;
          out_rsp_nxt.count_value = count_inc;
        end else if (scan_sts.free) begin
          // claim the lowest free slot, first message counts as one
          ram_we                  = 1'b1;
          ram_waddr               = free_idx;
          ram_wdata               = '{valid: 1'b1, key: req_key, count: COUNT_W'(1)};
          out_rsp_nxt.status      = ST_COUNTED;
          out_rsp_nxt.count_value = COUNT_W'(1);
        end else begin
          out_rsp_nxt.status      = ST_FULL;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        idx_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_idx_r  <= rd_idx_nxt;
    req_r     <= req_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

`ifndef NO_ASSERTIONS
  a_strobe_after_decide: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_DECIDE))
    else $error("result strobe without a finished scan");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLEAR || state_r == S_DECIDE))
    else $error("table written during scan");

  a_counted_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.status == ST_COUNTED) |-> (out_rsp.count_value != '0))
    else $error("counted result with zero count");
`endif

endmodule
`default_nettype wire

>>> rtl/fkpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fkpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/fkpc_scan.sv
// Key compare unit: walks the entry stream, keeps first match and first free slot.
`default_nettype none
module fkpc_scan
  import fkpc_pkg::*;
#(
  parameter int AW = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire scan_ctl_t            ctl,
  input  wire logic [AW-1:0]        rd_idx,
  input  wire logic [KEY_W-1:0]     key,
  input  wire entry_t               rd_entry,
  output scan_sts_t                 sts,
  output logic      [AW-1:0]        hit_idx,
  output logic      [AW-1:0]        free_idx,
  output logic      [COUNT_W-1:0]   hit_count
);

  scan_sts_t          sts_r, sts_nxt;
  logic [AW-1:0]      hit_idx_r, hit_idx_nxt;
  logic [AW-1:0]      free_idx_r, free_idx_nxt;
  logic [COUNT_W-1:0] hit_count_r, hit_count_nxt;
  logic               key_eq;

  assign key_eq = rd_entry.valid && (rd_entry.key == key);

  always_comb begin
    sts_nxt       = sts_r;
    hit_idx_nxt   = hit_idx_r;
    free_idx_nxt  = free_idx_r;
    hit_count_nxt = hit_count_r;
    if (ctl.clr) begin
      sts_nxt = '0;
    end else if (ctl.vld) begin
      // keep only the first match and the lowest free slot
      if (key_eq && !sts_r.hit) begin
        sts_nxt.hit   = 1'b1;
        hit_idx_nxt   = rd_idx;
        hit_count_nxt = rd_entry.count;
      end
      if (!rd_entry.valid && !sts_r.free) begin
        sts_nxt.free = 1'b1;
        free_idx_nxt = rd_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sts_r <= '0;
    end else begin
      sts_r <= sts_nxt;
    end
    hit_idx_r   <= hit_idx_nxt;
    free_idx_r  <= free_idx_nxt;
    hit_count_r <= hit_count_nxt;
  end

  assign sts       = sts_r;
  assign hit_idx   = hit_idx_r;
  assign free_idx  = free_idx_r;
  assign hit_count = hit_count_r;

endmodule
`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the flow-keyed packet counter table.
module testbench;
  import fkpc_pkg::*;

  localparam int FLOW_SLOTS  = 16;
  localparam int KEY_POOL    = 24;
  localparam int RANDOM_REQS = 1150;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t rsp;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  req_t in_req;
  logic out_valid;
  rsp_t out_rsp;

  // Shadow copy of the flow table
  bit                 flow_live  [FLOW_SLOTS];
  logic [KEY_W-1:0]   flow_key   [FLOW_SLOTS];
  logic [COUNT_W-1:0] flow_count [FLOW_SLOTS];

  rsp_t     rsp_due[$];
  dir_row_t dir_rows[$];
  req_t     key_pool[KEY_POOL];
  int       mismatches;
  int       reqs_sent;
  int       burst_left;
  int       status_seen[4];

  flow_keyed_packet_counter_table #(
    .TABLE_ENTRIES(FLOW_SLOTS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic rsp_t account_request(req_t r);
    logic [KEY_W-1:0] k;
    int               slot;
    rsp_t             res;
    k = {r.src_addr, r.src_port};
    slot = -1;
    res = '0;
    // Scan downward so the lowest matching index wins
    for (int i = FLOW_SLOTS - 1; i >= 0; i--) begin
      if (flow_live[i] && flow_key[i] == k) slot = i;
    end
    if (r.req_type == REQ_CLOSE) begin
      if (slot >= 0) begin
        flow_live[slot] = 1'b0;
        res.status = ST_REMOVED;
      end else begin
        res.status = ST_UNKNOWN;
      end
    end else begin
      if (slot < 0) begin
        for (int i = FLOW_SLOTS - 1; i >= 0; i--) begin
          if (!flow_live[i]) slot = i;
        end
        if (slot >= 0) begin
          flow_live[slot]  = 1'b1;
          flow_key[slot]   = k;
          flow_count[slot] = '0;
        end
      end
      if (slot < 0) begin
        res.status = ST_FULL;
      end else begin
        if (flow_count[slot] != '1) flow_count[slot] = flow_count[slot] + 1'b1;
        res.status      = ST_COUNTED;
        res.count_value = flow_count[slot];
      end
    end
    return res;
  endfunction

  function automatic void add_row(req_kind_t kind, logic [31:0] addr, logic [15:0] port,
                                  bit typed, status_t st, logic [31:0] cnt);
    dir_row_t row;
    row.req.req_type    = kind;
    row.req.src_addr    = addr;
    row.req.src_port    = port;
    row.typed           = typed;
    row.rsp.status      = st;
    row.rsp.count_value = cnt;
    dir_rows.push_back(row);
  endfunction

  // Mostly short gaps, a few long ones, and now and then a back-to-back burst
  function automatic int pick_gap();
    int sel;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    sel = $urandom_range(0, 99);
    if (sel < 3) begin
      burst_left = $urandom_range(20, 50);
      return 0;
    end
    if (sel < 45) return 0;
    if (sel < 88) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic req_t pick_flow();
    req_t r;
    if ($urandom_range(0, 99) < 85) begin
      r = key_pool[$urandom_range(0, KEY_POOL - 1)];
    end else begin
      r.src_addr = $urandom;
      r.src_port = 16'($urandom_range(0, 65535));
    end
    return r;
  endfunction

  task automatic issue_request(req_t r, bit typed, rsp_t typed_rsp, int gap);
    rsp_t model_rsp;
    in_req <= r;
    start  <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    // Request taken at this edge; the shadow table advances even for typed rows
    model_rsp = account_request(r);
    rsp_due.push_back(typed ? typed_rsp : model_rsp);
    reqs_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin : rsp_check
    rsp_t want;
    if (rst_n && out_valid) begin
      if (rsp_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: status %0d count %0d",
                   out_rsp.status, out_rsp.count_value);
      end else begin
        want = rsp_due.pop_front();
        status_seen[want.status]++;
        if (out_rsp.status !== want.status || out_rsp.count_value !== want.count_value) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: status exp %0d got %0d, count exp %0d got %0d",
                     want.status, out_rsp.status, want.count_value, out_rsp.count_value);
        end
      end
    end
  end

  initial begin
    req_t r;
    int   close_pct;
    rst_n  <= 1'b0;
    start  <= 1'b0;
    in_req <= '0;
    mismatches = 0;
    reqs_sent  = 0;
    burst_left = 0;
    foreach (flow_live[i]) flow_live[i] = 1'b0;
    foreach (status_seen[i]) status_seen[i] = 0;

    // Pool keys share an address or a port with a neighbor to exercise partial matches
    for (int i = 0; i < KEY_POOL; i++) begin
      key_pool[i].req_type = REQ_COUNT;
      key_pool[i].src_addr = $urandom;
      key_pool[i].src_port = 16'($urandom_range(0, 65535));
      if (i % 3 == 1) key_pool[i].src_addr = key_pool[i-1].src_addr;
      if (i % 3 == 2) key_pool[i].src_port = key_pool[i-1].src_port;
    end

    add_row(REQ_CLOSE, 32'h0, 16'h0, 1'b1, ST_UNKNOWN, 32'd0);
    add_row(REQ_COUNT, 32'h0, 16'h0, 1'b1, ST_COUNTED, 32'd1);
    add_row(REQ_COUNT, '1,    '1,    1'b1, ST_COUNTED, 32'd1);
    add_row(REQ_COUNT, 32'h0, '1,    1'b1, ST_COUNTED, 32'd1);
    add_row(REQ_COUNT, '1,    16'h0, 1'b1, ST_COUNTED, 32'd1);
    add_row(REQ_CLOSE, 32'h0, 16'h0, 1'b1, ST_REMOVED, 32'd0);
    add_row(REQ_CLOSE, 32'h0, 16'h0, 1'b1, ST_UNKNOWN, 32'd0);
    add_row(REQ_COUNT, 32'h0, 16'h0, 1'b1, ST_COUNTED, 32'd1);
    add_row(REQ_CLOSE, '1,    '1,    1'b1, ST_REMOVED, 32'd0);
    add_row(REQ_COUNT, 32'h0, 16'h0, 1'b0, ST_COUNTED, 32'd0);
    // Three flows live now; fill the rest of the table
    for (int i = 0; i < FLOW_SLOTS - 3; i++)
      add_row(REQ_COUNT, 32'hC0DE_0000 | 32'(i), 16'(16'h1000 + i), 1'b1, ST_COUNTED,
              32'd1);
    add_row(REQ_COUNT, 32'h8000_0000, 16'h8000, 1'b1, ST_FULL, 32'd0);
    add_row(REQ_CLOSE, 32'h0, '1, 1'b1, ST_REMOVED, 32'd0);
    add_row(REQ_COUNT, 32'h8000_0000, 16'h8000, 1'b0, ST_COUNTED, 32'd0);
    // Counter saturation needs 2^32 counts on one flow and is out of reach here.

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      issue_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp, pick_gap());

    // Alternate fill-heavy and close-heavy phases so the table swings between full and sparse
    for (int n = 0; n < RANDOM_REQS; n++) begin
      close_pct = ((n / 150) % 2 == 1) ? 45 : 12;
      r = pick_flow();
      r.req_type = ($urandom_range(0, 99) < close_pct) ? REQ_CLOSE : REQ_COUNT;
      issue_request(r, 1'b0, '0, pick_gap());
    end
    start <= 1'b0;

    while (rsp_due.size() != 0) @(posedge clk);
    repeat (2 * FLOW_SLOTS + 8) @(posedge clk);

    $display("covered %0d requests (%0d directed): %0d counted, %0d removed,",
             reqs_sent, dir_rows.size(), status_seen[ST_COUNTED], status_seen[ST_REMOVED]);
    $display("%0d closes of unknown flows, %0d dropped on a full table, %0d mismatches",
             status_seen[ST_UNKNOWN], status_seen[ST_FULL], mismatches);
    if (mismatches == 0) begin
      $display("[flow_keyed_packet_counter_table] OK");
    end else begin
      $display("[flow_keyed_packet_counter_table] ERROR");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d results outstanding", rsp_due.size());
    $display("[flow_keyed_packet_counter_table] ERROR");
    $finish;
  end

endmodule

>>> flow_keyed_packet_counter_table.f
rtl/fkpc_pkg.sv
rtl/fkpc_ram.sv
rtl/fkpc_scan.sv
rtl/flow_keyed_packet_counter_table.sv
verif/testbench.sv
